// File: hw/rtl/salc_pkg.sv
package salc_pkg;

    // Default sizes of the tag store and the address.
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_BITS    = 48;

    // Configuration register widths, indexes and reset values.
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 5;
    localparam int SET_BITS_W      = 3;
    localparam int WAYS_W          = 4;
    localparam int OFFSET_BITS_W   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAYS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET_BITS = 2'd2;

    localparam logic [SET_BITS_W-1:0]    RST_SET_BITS    = 3'd4;
    localparam logic [WAYS_W-1:0]        RST_WAYS_IN_USE = 4'd1;
    localparam logic [OFFSET_BITS_W-1:0] RST_OFFSET_BITS = 5'd4;

    // Access kinds. The fourth code behaves as a load.
    localparam int OPCODE_W = 2;
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MODIFY = 2'd2;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    localparam int TOTAL_W = 32;

    // Saturating add of a small increment to a running total.
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [1:0] inc);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + {{(TOTAL_W-1){1'b0}}, inc};
        return sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    endfunction

endpackage

// File: hw/rtl/salc_req_if.sv
interface salc_req_if
    import salc_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] address;
    logic [OPCODE_W-1:0]  opcode;

    modport source (output valid, output address, output opcode, input ready);
    modport sink   (input valid, input address, input opcode, output ready);
endinterface

// File: hw/rtl/salc_rsp_if.sv
interface salc_rsp_if
    import salc_pkg::*;
;
    logic               valid;
    logic               ready;
    t_outcome           outcome;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] eviction_total;

    modport source (output valid, output outcome, output hit_total, output miss_total,
                    output eviction_total, input ready);
    modport sink   (input valid, input outcome, input hit_total, input miss_total,
                    input eviction_total, output ready);
endinterface

// File: hw/rtl/set_assoc_lru_cache_tags_top.sv
// Tag store of a set-associative cache with true LRU replacement. Each request
// transaction carries a byte address and an access kind (load, store, modify);
// each response transaction reports hit, miss that filled an empty way, or miss
// that evicted the least recently used way, together with the saturating hit,
// miss and eviction totals after that access (a modify counts one extra hit).
// The block takes one request per cycle while no sweep runs and the response
// register is free or drained, and returns its response through two registers:
// the registered read of the set from the tag memory, then the response
// register, loaded by the parallel compare and LRU update, which also writes the
// set back. The single read port and single write port of the tag memory set
// that rate; a request to the set that the previous request is updating gets the
// updated set through a bypass. After reset the valid bits and ranks are swept
// clear, one set per cycle, over all 2^MAX_SET_BITS sets (64 by default); no
// request is taken during the sweep, but configuration writes are. Configure
// set_bits, ways_in_use and offset_bits only while no transaction is in flight.
module set_assoc_lru_cache_tags_top
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    salc_req_if.sink              i_req,
    salc_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int SetW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RankW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CntW  = $clog2(MAX_WAYS + 1);
    localparam int SbW   = 4;
    localparam int ShW   = 6;

    // Configuration registers.
    logic [SET_BITS_W-1:0]    r_set_bits;
    logic [WAYS_W-1:0]        r_ways;
    logic [OFFSET_BITS_W-1:0] r_offset_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= RST_SET_BITS;
            r_ways        <= RST_WAYS_IN_USE;
            r_offset_bits <= RST_OFFSET_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_SET_BITS:    r_set_bits    <= i_cfg_data[SET_BITS_W-1:0];
                CFG_IDX_WAYS_IN_USE: r_ways        <= i_cfg_data[WAYS_W-1:0];
                CFG_IDX_OFFSET_BITS: r_offset_bits <= i_cfg_data[OFFSET_BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective set index width and way limit after clamping to the store size.
    logic [SbW-1:0]  eff_sb;
    logic [CntW-1:0] eff_ways;

    assign eff_sb = (32'(r_set_bits) > MAX_SET_BITS) ? SbW'(MAX_SET_BITS)
                                                     : SbW'(r_set_bits);
    assign eff_ways = (r_ways == '0)                ? CntW'(1) :
                      (32'(r_ways) > MAX_WAYS)      ? CntW'(MAX_WAYS) :
                                                      CntW'(r_ways);

    // Address split for the incoming request.
    logic [ADDR_BITS-1:0] addr_shifted;
    logic [SetW-1:0]      set_mask;
    logic [SetW-1:0]      in_set;
    logic [ShW-1:0]       tag_shift;
    logic [ADDR_BITS-1:0] in_tag;

    always_comb begin
        for (int i = 0; i < SetW; i++) begin
            set_mask[i] = (i < 32'(eff_sb));
        end
    end

    assign addr_shifted = i_req.address >> r_offset_bits;
    assign in_set       = addr_shifted[SetW-1:0] & set_mask;
    assign tag_shift    = ShW'(r_offset_bits) + ShW'(eff_sb);
    assign in_tag       = i_req.address >> tag_shift;

    // Handshake control.
    logic     clr_busy;
    logic     req_acc;
    logic     b_adv;
    logic     r_b_valid;
    logic     r_out_valid;
    t_outcome r_out_outcome;

    assign b_adv       = r_b_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !clr_busy && (!r_b_valid || b_adv);
    assign req_acc     = i_req.valid && i_req.ready;

    // Lookup stage registers and the same-set bypass.
    logic [ADDR_BITS-1:0]               r_b_tag;
    logic [OPCODE_W-1:0]                r_b_op;
    logic [SetW-1:0]                    r_b_set;
    logic                               r_fwd;
    logic [MAX_WAYS-1:0]                r_fwd_valid;
    logic [MAX_WAYS-1:0][RankW-1:0]     r_fwd_rank;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] r_fwd_tag;

    logic [MAX_WAYS-1:0]                mem_valid;
    logic [MAX_WAYS-1:0][RankW-1:0]     mem_rank;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] mem_tag;
    logic [MAX_WAYS-1:0]                row_valid;
    logic [MAX_WAYS-1:0][RankW-1:0]     row_rank;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] row_tag;
    logic [MAX_WAYS-1:0]                lk_valid;
    logic [MAX_WAYS-1:0][RankW-1:0]     lk_rank;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] lk_tag;
    t_outcome                           lk_outcome;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else if (req_acc) begin
            r_b_valid <= 1'b1;
            // The set being written back this cycle is not yet visible in memory.
            r_fwd     <= b_adv && (r_b_set == in_set);
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_b_tag     <= in_tag;
            r_b_op      <= i_req.opcode;
            r_b_set     <= in_set;
            r_fwd_valid <= lk_valid;
            r_fwd_rank  <= lk_rank;
            r_fwd_tag   <= lk_tag;
        end
    end

    salc_tag_mem #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (req_acc),
        .i_rd_set   (in_set),
        .o_rd_valid (mem_valid),
        .o_rd_rank  (mem_rank),
        .o_rd_tag   (mem_tag),
        .i_wr_en    (b_adv),
        .i_wr_set   (r_b_set),
        .i_wr_valid (lk_valid),
        .i_wr_rank  (lk_rank),
        .i_wr_tag   (lk_tag),
        .o_clr_busy (clr_busy)
    );

    assign row_valid = r_fwd ? r_fwd_valid : mem_valid;
    assign row_rank  = r_fwd ? r_fwd_rank  : mem_rank;
    assign row_tag   = r_fwd ? r_fwd_tag   : mem_tag;

    salc_lookup #(
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_lookup (
        .i_valid      (row_valid),
        .i_rank       (row_rank),
        .i_tag        (row_tag),
        .i_access_tag (r_b_tag),
        .i_ways       (eff_ways),
        .o_outcome    (lk_outcome),
        .o_valid      (lk_valid),
        .o_rank       (lk_rank),
        .o_tag        (lk_tag)
    );

    // Running totals. They change only when a new response is loaded, so they
    // double as the response payload.
    logic [TOTAL_W-1:0] r_hits;
    logic [TOTAL_W-1:0] r_misses;
    logic [TOTAL_W-1:0] r_evicts;
    logic [1:0]         hit_inc;

    assign hit_inc = {1'b0, lk_outcome == OUT_HIT} + {1'b0, r_b_op == OP_MODIFY};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (b_adv) begin
                r_hits      <= sat_add(r_hits, hit_inc);
                r_misses    <= sat_add(r_misses, {1'b0, lk_outcome != OUT_HIT});
                r_evicts    <= sat_add(r_evicts, {1'b0, lk_outcome == OUT_EVICT});
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out_outcome <= lk_outcome;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.outcome        = r_out_outcome;
    assign o_rsp.hit_total      = r_hits;
    assign o_rsp.miss_total     = r_misses;
    assign o_rsp.eviction_total = r_evicts;

    // A bypassed set always belongs to a request held in the lookup stage.
    a_fwd_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_b_valid)
        else $error("bypass active without a request in the lookup stage");

    // Only a fill adds a valid line to a set; hits and evictions keep the count.
    a_valid_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_adv |-> ($countones(lk_valid) ==
                   $countones(row_valid) + ((lk_outcome == OUT_FILL) ? 1 : 0)))
        else $error("valid line count changed by an unexpected amount");

    // An eviction always leaves a nonzero eviction total behind it.
    a_evict_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && lk_outcome == OUT_EVICT) |=> (r_evicts != '0))
        else $error("eviction not counted");

    // No request is taken while the store is being swept clear.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |=> !r_b_valid || $past(r_b_valid))
        else $error("request accepted during the clearing sweep");
endmodule

// File: hw/rtl/salc_tag_mem.sv
module salc_tag_mem
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    localparam int SetW        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    localparam int RankW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rd_en,
    input  logic [SetW-1:0]                      i_rd_set,
    output logic [MAX_WAYS-1:0]                  o_rd_valid,
    output logic [MAX_WAYS-1:0][RankW-1:0]       o_rd_rank,
    output logic [MAX_WAYS-1:0][ADDR_BITS-1:0]   o_rd_tag,
    input  logic                                 i_wr_en,
    input  logic [SetW-1:0]                      i_wr_set,
    input  logic [MAX_WAYS-1:0]                  i_wr_valid,
    input  logic [MAX_WAYS-1:0][RankW-1:0]       i_wr_rank,
    input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0]   i_wr_tag,
    output logic                                 o_clr_busy
);
    localparam int Sets  = 1 << MAX_SET_BITS;

    logic [MAX_WAYS-1:0]                valid_mem [Sets];
    logic [MAX_WAYS-1:0][RankW-1:0]     rank_mem  [Sets];
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem   [Sets];

    logic            r_clr_busy;
    logic [SetW-1:0] r_clr_idx;

    // Valid bits and ranks are swept to zero one set per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == SetW'(Sets - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            valid_mem[r_clr_idx] <= '0;
            rank_mem[r_clr_idx]  <= '0;
        end else if (i_wr_en) begin
            valid_mem[i_wr_set] <= i_wr_valid;
            rank_mem[i_wr_set]  <= i_wr_rank;
            tag_mem[i_wr_set]   <= i_wr_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_valid <= valid_mem[i_rd_set];
            o_rd_rank  <= rank_mem[i_rd_set];
            o_rd_tag   <= tag_mem[i_rd_set];
        end
    end

    assign o_clr_busy = r_clr_busy;
endmodule

// File: hw/rtl/salc_lookup.sv
module salc_lookup
    import salc_pkg::*;
#(
    parameter int MAX_WAYS  = DEF_MAX_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    localparam int RankW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int CntW     = $clog2(MAX_WAYS + 1)
) (
    input  logic [MAX_WAYS-1:0]                i_valid,
    input  logic [MAX_WAYS-1:0][RankW-1:0]     i_rank,
    input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] i_tag,
    input  logic [ADDR_BITS-1:0]               i_access_tag,
    input  logic [CntW-1:0]                    i_ways,
    output t_outcome                           o_outcome,
    output logic [MAX_WAYS-1:0]                o_valid,
    output logic [MAX_WAYS-1:0][RankW-1:0]     o_rank,
    output logic [MAX_WAYS-1:0][ADDR_BITS-1:0] o_tag
);
    localparam int WayW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic             hit_found;
    logic [WayW-1:0]  hit_way;
    logic             free_found;
    logic [WayW-1:0]  free_way;
    logic [CntW-1:0]  valid_n;
    logic [RankW-1:0] max_rank;
    logic [WayW-1:0]  old_way;
    logic [WayW-1:0]  use_way;
    logic             age_all;
    logic [RankW-1:0] limit_rank;

    always_comb begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        valid_n    = '0;
        max_rank   = '0;
        old_way    = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            valid_n = valid_n + CntW'(i_valid[w]);
            if (i_valid[w] && i_tag[w] == i_access_tag && !hit_found) begin
                hit_found = 1'b1;
                hit_way   = WayW'(w);
            end
            if (!i_valid[w] && !free_found) begin
                free_found = 1'b1;
                free_way   = WayW'(w);
            end
            if (i_valid[w] && i_rank[w] > max_rank) begin
                max_rank = i_rank[w];
            end
        end
        // The oldest line is the highest valid way holding the largest rank.
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (i_valid[w] && i_rank[w] == max_rank) begin
                old_way = WayW'(w);
            end
        end

        if (hit_found) begin
            o_outcome  = OUT_HIT;
            use_way    = hit_way;
            age_all    = 1'b0;
            limit_rank = i_rank[hit_way];
        end else if (valid_n < i_ways && free_found) begin
            o_outcome  = OUT_FILL;
            use_way    = free_way;
            age_all    = 1'b1;
            limit_rank = '0;
        end else begin
            o_outcome  = OUT_EVICT;
            use_way    = old_way;
            age_all    = 1'b0;
            limit_rank = max_rank;
        end

        // Lines younger than the touched or replaced one age by one; on a fill every valid line ages.
        o_valid = i_valid;
        o_tag   = i_tag;
        for (int w = 0; w < MAX_WAYS; w++) begin
            o_rank[w] = i_rank[w];
            if (i_valid[w] && WayW'(w) != use_way && (age_all || i_rank[w] < limit_rank)) begin
                o_rank[w] = i_rank[w] + 1'b1;
            end
        end
        o_valid[use_way] = 1'b1;
        o_tag[use_way]   = i_access_tag;
        o_rank[use_way]  = '0;
    end
endmodule
